// File: sv/mmlr_pkg.sv
// Shared constants and types for the min/max level rescaler.
package mmlr_pkg;

  // Default sample width and the fixed width of levels and span.
  localparam int unsigned SampleBitsDef = 32;
  localparam int unsigned SpanBits      = 16;

  // Configuration register indexes.
  localparam logic CfgOutMin = 1'b0;
  localparam logic CfgOutMax = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [SpanBits-1:0] OutMinRst = 16'd0;
  localparam logic [SpanBits-1:0] OutMaxRst = 16'd255;

  // Operation codes carried in the input tuser.
  localparam logic OpMeasure = 1'b0;
  localparam logic OpConvert = 1'b1;

  // Bit positions in the input tuser.
  localparam int unsigned UserOpBit    = 0;
  localparam int unsigned UserFirstBit = 1;

  // Divider status toward the sequencer.
  typedef struct packed {
    logic                busy;
    logic                done;
    logic [SpanBits-1:0] quot;
  } div_status_t;

endpackage

// File: sv/mmlr_scale_div.sv
// Shared add/compare/subtract unit computing floor(d * span / range) bit serially.
module mmlr_scale_div #(
  parameter int unsigned SAMPLE_BITS = mmlr_pkg::SampleBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [SAMPLE_BITS-1:0]            d_i,
  input  logic [SAMPLE_BITS-1:0]            range_i,
  input  logic [mmlr_pkg::SpanBits-1:0]     span_i,
  output mmlr_pkg::div_status_t             status_o
);

  localparam int unsigned Steps  = 2 * mmlr_pkg::SpanBits;
  localparam int unsigned CntW   = $clog2(Steps);
  localparam logic [CntW-1:0] LastStep = CntW'(Steps - 1);

  logic                          busy_q;
  logic                          done_q;
  logic [CntW-1:0]               cnt_q;
  logic [SAMPLE_BITS-1:0]        d_q;
  logic [SAMPLE_BITS-1:0]        range_q;
  logic [SAMPLE_BITS-1:0]        rem_q;
  logic [mmlr_pkg::SpanBits-1:0] span_q;
  logic [mmlr_pkg::SpanBits-1:0] quot_q;

  logic                   phase;
  logic [SAMPLE_BITS-1:0] addend;
  logic [SAMPLE_BITS:0]   sum;
  logic [SAMPLE_BITS:0]   range_ext;
  logic                   ge;
  logic [SAMPLE_BITS:0]   diff;
  logic [SAMPLE_BITS-1:0] rem_d;

  // Even steps double the remainder, odd steps add d when the span bit is set.
  always_comb begin
    phase     = cnt_q[0];
    addend    = phase ? (span_q[mmlr_pkg::SpanBits-1] ? d_q : '0) : rem_q;
    sum       = {1'b0, rem_q} + {1'b0, addend};
    range_ext = {1'b0, range_q};
    ge        = (sum >= range_ext);
    diff      = sum - range_ext;
    rem_d     = ge ? diff[SAMPLE_BITS-1:0] : sum[SAMPLE_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LastStep) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      d_q     <= d_i;
      range_q <= range_i;
      span_q  <= span_i;
      rem_q   <= '0;
      quot_q  <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      if (phase) begin
        quot_q <= quot_q + {{(mmlr_pkg::SpanBits-1){1'b0}}, ge};
        span_q <= {span_q[mmlr_pkg::SpanBits-2:0], 1'b0};
      end else begin
        quot_q <= {quot_q[mmlr_pkg::SpanBits-2:0], ge};
      end
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign status_o.quot = quot_q;

endmodule

// File: sv/minmax_level_rescaler.sv
// Two-pass min/max contrast stretch: frame statistics, then rescaling of each sample.
// Measure words update the statistics while the block stays idle, so the input stays ready.
// Convert words needing a division: the divider runs 32 steps, two per span bit, then
// raises done; the sequencer loads the quotient, registers the level and takes the next word.
// Convert words settled without division go straight to StDone; a full output stalls the input.
// Reset clears statistics to (0, 0), sets out_min 0 and out_max 255, and empties the output.
module minmax_level_rescaler #(
  parameter int unsigned SAMPLE_BITS = mmlr_pkg::SampleBitsDef
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // Input stream.
  input  logic                                   s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] s_axis_tdata_i,  // [SAMPLE_BITS-1:0] sample
  input  logic [1:0]                             s_axis_tuser_i,  // [0] operation, [1] first
  // Output stream.
  output logic                                   m_axis_tvalid_o,
  input  logic                                   m_axis_tready_i,
  output logic [mmlr_pkg::SpanBits-1:0]          m_axis_tdata_o,  // [15:0] level
  output logic [0:0]                             m_axis_tuser_o,  // [0] zero_range
  // Configuration write channel.
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic                                   cfg_index_i,
  input  logic [mmlr_pkg::SpanBits-1:0]          cfg_data_i
);

  typedef enum logic [1:0] {
    StIdle,
    StDiv,
    StDone
  } state_e;

  state_e                        state_q;
  logic [SAMPLE_BITS-1:0]        low_q;       // offset-binary running minimum
  logic [SAMPLE_BITS-1:0]        high_q;      // offset-binary running maximum
  logic                          stats_vld_q;
  logic [mmlr_pkg::SpanBits-1:0] out_min_q;
  logic [mmlr_pkg::SpanBits-1:0] out_max_q;
  logic [mmlr_pkg::SpanBits-1:0] res_level_q;
  logic                          res_zr_q;
  logic                          out_vld_q;
  logic [mmlr_pkg::SpanBits-1:0] out_level_q;
  logic                          out_zr_q;

  logic                          in_acc;
  logic                          op;
  logic                          first;
  logic [SAMPLE_BITS-1:0]        x_biased;
  logic [SAMPLE_BITS-1:0]        range;
  logic [SAMPLE_BITS-1:0]        delta;
  logic [mmlr_pkg::SpanBits-1:0] span;
  logic                          zero_case;
  logic                          below;
  logic                          above;
  logic                          div_start;
  logic                          out_free;
  mmlr_pkg::div_status_t         div_status;

  // Flip the sign bit so unsigned compares order the samples.
  always_comb begin
    op       = s_axis_tuser_i[mmlr_pkg::UserOpBit];
    first    = s_axis_tuser_i[mmlr_pkg::UserFirstBit];
    x_biased = {~s_axis_tdata_i[SAMPLE_BITS-1], s_axis_tdata_i[SAMPLE_BITS-2:0]};
    in_acc   = s_axis_tvalid_i && s_axis_tready_o;
    range    = high_q - low_q;
    delta    = x_biased - low_q;
    span     = out_max_q - out_min_q;
    // Zero range or a span that is not positive forces level 0 with the flag.
    zero_case = (range == '0) || (out_max_q <= out_min_q);
    below     = (x_biased < low_q);
    above     = (x_biased >= high_q);
    div_start = in_acc && (op == mmlr_pkg::OpConvert) && !zero_case && !below && !above;
    out_free  = !out_vld_q || m_axis_tready_i;
  end

  assign s_axis_tready_o = (state_q == StIdle);
  assign cfg_ready_o     = 1'b1;

  mmlr_scale_div #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .d_i     (delta),
    .range_i (range),
    .span_i  (span),
    .status_o(div_status)
  );

  // Sequencer, statistics, configuration and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      low_q       <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      high_q      <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      stats_vld_q <= 1'b0;
      out_min_q   <= mmlr_pkg::OutMinRst;
      out_max_q   <= mmlr_pkg::OutMaxRst;
      res_level_q <= '0;
      res_zr_q    <= 1'b0;
      out_vld_q   <= 1'b0;
      out_level_q <= '0;
      out_zr_q    <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          mmlr_pkg::CfgOutMin: out_min_q <= cfg_data_i;
          mmlr_pkg::CfgOutMax: out_max_q <= cfg_data_i;
          default: ;
        endcase
      end

      // Drop the output word once the sink takes it, unless a new one loads now.
      if (out_vld_q && m_axis_tready_i && (state_q != StDone)) begin
        out_vld_q <= 1'b0;
      end

      case (state_q)
        StIdle: begin
          if (in_acc) begin
            if (op == mmlr_pkg::OpMeasure) begin
              // Restart on first, or when no statistics exist yet.
              if (first || !stats_vld_q) begin
                low_q       <= x_biased;
                high_q      <= x_biased;
                stats_vld_q <= 1'b1;
              end else begin
                if (below) low_q <= x_biased;
                if (x_biased > high_q) high_q <= x_biased;
              end
            end else if (zero_case) begin
              res_level_q <= '0;
              res_zr_q    <= 1'b1;
              state_q     <= StDone;
            end else if (below) begin
              res_level_q <= '0;
              res_zr_q    <= 1'b0;
              state_q     <= StDone;
            end else if (above) begin
              // Saturate to the span.
              res_level_q <= span;
              res_zr_q    <= 1'b0;
              state_q     <= StDone;
            end else begin
              res_zr_q <= 1'b0;
              state_q  <= StDiv;
            end
          end
        end
        StDiv: begin
          // Hold until the divider finishes its last step.
          if (div_status.done) begin
            res_level_q <= div_status.quot;
            state_q     <= StDone;
          end
        end
        StDone: begin
          if (out_free) begin
            out_vld_q   <= 1'b1;
            out_level_q <= res_level_q;
            out_zr_q    <= res_zr_q;
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign m_axis_tvalid_o   = out_vld_q;
  assign m_axis_tdata_o    = out_level_q;
  assign m_axis_tuser_o[0] = out_zr_q;

endmodule

// File: verif/minmax_level_rescaler_tb.sv
// Self-checking testbench for the min/max level rescaler: stream driver, monitor and predictor.
module minmax_level_rescaler_tb;

  localparam int unsigned SmpW         = mmlr_pkg::SampleBitsDef;
  localparam int unsigned HalfPeriod   = 6;
  localparam int unsigned ResetCycles  = 4;
  localparam int unsigned SettleCycles = 48;      // a little over one division
  localparam int unsigned HoldLen      = 400;     // long receiver hold-off
  localparam int unsigned PhaseWords   = 64;      // random words per setting
  localparam int unsigned CycleLimit   = 600000;
  localparam int unsigned NumSettings  = 9;

  // One input word: operation, sample and restart flag.
  typedef struct packed {
    logic            op;
    logic [SmpW-1:0] smp;
    logic            first;
  } sample_word_t;

  // One result word: level and zero-range flag.
  typedef struct packed {
    logic [mmlr_pkg::SpanBits-1:0] level;
    logic                          zero_range;
  } level_result_t;

  // Clock, reset and block ports; every input starts at a known value.
  logic                          clk_i           = 1'b0;
  logic                          rst_ni          = 1'b0;
  logic                          s_axis_tvalid_i = 1'b0;
  logic                          s_axis_tready_o;
  logic [SmpW-1:0]               s_axis_tdata_i  = '0;      // [31:0] sample
  logic [1:0]                    s_axis_tuser_i  = '0;      // [0] operation, [1] first
  logic                          m_axis_tvalid_o;
  logic                          m_axis_tready_i = 1'b0;
  logic [mmlr_pkg::SpanBits-1:0] m_axis_tdata_o;            // [15:0] level
  logic [0:0]                    m_axis_tuser_o;            // [0] zero_range
  logic                          cfg_valid_i     = 1'b0;
  logic                          cfg_ready_o;
  logic                          cfg_index_i     = mmlr_pkg::CfgOutMin;
  logic [mmlr_pkg::SpanBits-1:0] cfg_data_i      = '0;

  // Predictor state: statistics kept offset-binary so plain compares order them.
  logic [SmpW-1:0]               stat_lo  = '0;
  logic [SmpW-1:0]               stat_hi  = '0;
  logic                          stat_ok  = 1'b0;
  logic [mmlr_pkg::SpanBits-1:0] lvl_min  = mmlr_pkg::OutMinRst;
  logic [mmlr_pkg::SpanBits-1:0] lvl_max  = mmlr_pkg::OutMaxRst;

  sample_word_t  sample_backlog[$];
  level_result_t level_expect[$];
  sample_word_t  cur_word;
  level_result_t got_level, want_level;

  int unsigned words_queued   = 0;
  int unsigned words_sent     = 0;
  int unsigned levels_checked = 0;
  int unsigned zero_ranges    = 0;
  int unsigned level_errors   = 0;
  int unsigned reg_writes     = 0;
  int unsigned cycle_count    = 0;
  int unsigned tx_gap = 0, tx_calm = 0;
  int unsigned rx_stall = 0, rx_calm = 0;
  int unsigned hold_cycles = 0;
  logic        hold_req = 1'b0;
  logic        rx_hold  = 1'b0;

  minmax_level_rescaler #(
    .SAMPLE_BITS(SmpW)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #(HalfPeriod) clk_i = ~clk_i;

  // Idle length: mostly none or short, now and then long.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Predict the block's answer to one accepted word and advance the statistics.
  task automatic stretch_predict(input sample_word_t w);
    logic [SmpW-1:0]               xb, range, delta;
    logic [mmlr_pkg::SpanBits-1:0] span;
    logic [63:0]                   quot;
    level_result_t                 res;
    xb = w.smp ^ {1'b1, {(SmpW-1){1'b0}}};
    if (w.op == mmlr_pkg::OpMeasure) begin
      // Restart on the flag, or when no statistics exist yet.
      if (w.first || !stat_ok) begin
        stat_lo = xb;
        stat_hi = xb;
        stat_ok = 1'b1;
      end else begin
        if (xb < stat_lo) stat_lo = xb;
        if (xb > stat_hi) stat_hi = xb;
      end
    end else begin
      range = stat_hi - stat_lo;
      if (range == 0 || lvl_max <= lvl_min) begin
        // Degenerate range or span: level forced to zero, flag raised.
        res.level      = '0;
        res.zero_range = 1'b1;
      end else begin
        span           = lvl_max - lvl_min;
        res.zero_range = 1'b0;
        if (xb < stat_lo) begin
          res.level = '0;
        end else begin
          delta = xb - stat_lo;
          if (delta >= range) begin
            res.level = span;
          end else begin
            quot      = (64'(delta) * 64'(span)) / 64'(range);
            res.level = quot[mmlr_pkg::SpanBits-1:0];
          end
        end
      end
      level_expect.push_back(res);
    end
  endtask

  // Stream driver: predict on each accepted word, then present the next one after a gap.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        stretch_predict(cur_word);
        words_sent++;
      end
      // Hold the current word until it is taken.
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_axis_tvalid_i <= 1'b0;
        end else if (sample_backlog.size() > 0) begin
          cur_word = sample_backlog.pop_front();
          s_axis_tdata_i  <= cur_word.smp;
          s_axis_tuser_i  <= {cur_word.first, cur_word.op};
          s_axis_tvalid_i <= 1'b1;
          if (tx_calm > 0) begin
            tx_calm--;
            tx_gap = 0;
          end else begin
            tx_gap = idle_len();
            if ($urandom_range(0, 19) == 0) tx_calm = $urandom_range(10, 40);
          end
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Long hold-off of the receiver, counted here so the block backs up into its input.
  always @(posedge clk_i) begin
    if (hold_req && hold_cycles < HoldLen) begin
      rx_hold     <= 1'b1;
      hold_cycles <= hold_cycles + 1;
    end else begin
      rx_hold <= 1'b0;
    end
  end

  // Monitor: compare each taken level word with the oldest prediction, then pick tready.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got_level.level      = m_axis_tdata_o;
        got_level.zero_range = m_axis_tuser_o[0];
        if (level_expect.size() == 0) begin
          level_errors++;
          if (level_errors <= 10)
            $display("[%0d] unexpected level word: level %0d zero_range %0b",
                     cycle_count, got_level.level, got_level.zero_range);
        end else begin
          want_level = level_expect.pop_front();
          levels_checked++;
          if (want_level.zero_range) zero_ranges++;
          if (got_level !== want_level) begin
            level_errors++;
            if (level_errors <= 10)
              $display("[%0d] level mismatch: expected level %0d zero_range %0b, got %0d %0b",
                       cycle_count, want_level.level, want_level.zero_range,
                       got_level.level, got_level.zero_range);
          end
        end
      end
      if (rx_hold) begin
        m_axis_tready_i <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
        if (rx_calm > 0) begin
          rx_calm--;
        end else if ($urandom_range(0, 7) == 0) begin
          rx_stall = idle_len();
          if ($urandom_range(0, 15) == 0) rx_calm = $urandom_range(20, 80);
        end
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d levels still pending",
               cycle_count, level_expect.size());
      $display("** minmax_level_rescaler: FAILED **");
      $finish;
    end
  end

  task automatic queue_word(input logic op, input logic [SmpW-1:0] smp, input logic first);
    sample_word_t w;
    w.op    = op;
    w.smp   = smp;
    w.first = first;
    sample_backlog.push_back(w);
    words_queued++;
  endtask

  // Write one register; the handshake is seen on the pre-edge values.
  task automatic write_reg(input logic idx, input logic [mmlr_pkg::SpanBits-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == mmlr_pkg::CfgOutMin) lvl_min = val;
    else lvl_max = val;
    reg_writes++;
  endtask

  // Wait until every word is sent and answered, then let a trailing measure settle.
  task automatic drain();
    do @(negedge clk_i);
    while (sample_backlog.size() != 0 || s_axis_tvalid_i || level_expect.size() != 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  function automatic logic [SmpW-1:0] frame_sample(input int unsigned kind,
                                                    input logic [SmpW-1:0] base,
                                                    input logic [SmpW-1:0] spread);
    case (kind)
      0: return $urandom;
      1: return base + $urandom_range(0, spread);
      2: begin
        case ($urandom_range(0, 5))
          0: return {1'b1, {(SmpW-1){1'b0}}};
          1: return {1'b0, {(SmpW-1){1'b1}}};
          2: return '0;
          3: return '1;
          4: return 1;
          default: return $urandom;
        endcase
      end
      default: return base;
    endcase
  endfunction

  // One frame: a measure pass, then a convert pass over the same samples plus strays.
  task automatic add_frame();
    logic [SmpW-1:0] vals[$];
    logic [SmpW-1:0] base, spread;
    int unsigned     n, kind, i;
    n      = $urandom_range(1, 12);
    kind   = $urandom_range(0, 3);
    base   = $urandom;
    spread = $urandom_range(1, 5000);
    for (i = 0; i < n; i++) vals.push_back(frame_sample(kind, base, spread));
    for (i = 0; i < n; i++)
      queue_word(mmlr_pkg::OpMeasure, vals[i],
                 (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 19) == 0));
    for (i = 0; i < n; i++) begin
      queue_word(mmlr_pkg::OpConvert, vals[i], 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 4) == 0)
        queue_word(mmlr_pkg::OpConvert, $urandom, 1'($urandom_range(0, 1)));
    end
  endtask

  logic [mmlr_pkg::SpanBits-1:0] set_lo[NumSettings];
  logic [mmlr_pkg::SpanBits-1:0] set_hi[NumSettings];
  int unsigned                   phase_start;

  initial begin
    // Output range settings: full span, zero span, inverted, tiny, offset, random.
    set_lo[0] = 16'd0;     set_hi[0] = 16'd65535;
    set_lo[1] = 16'd65535; set_hi[1] = 16'd65535;
    set_lo[2] = 16'd300;   set_hi[2] = 16'd200;
    set_lo[3] = 16'd0;     set_hi[3] = 16'd1;
    set_lo[4] = 16'd1000;  set_hi[4] = 16'd1255;
    set_lo[5] = 16'd0;     set_hi[5] = 16'd0;
    set_lo[6] = 16'($urandom);  set_hi[6] = 16'($urandom);
    set_lo[7] = 16'($urandom_range(0, 255));  set_hi[7] = 16'($urandom_range(30000, 65535));
    set_lo[8] = 16'd1;     set_hi[8] = 16'd65535;

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed words under the reset range 0..255.
    queue_word(mmlr_pkg::OpConvert, 32'd0, 1'b0);           // convert with no statistics yet
    queue_word(mmlr_pkg::OpMeasure, -32'sd5, 1'b0);          // measure without flag starts stats
    queue_word(mmlr_pkg::OpMeasure, 32'd5, 1'b0);
    queue_word(mmlr_pkg::OpConvert, -32'sd5, 1'b0);          // at minimum
    queue_word(mmlr_pkg::OpConvert, 32'd5, 1'b1);            // at maximum
    queue_word(mmlr_pkg::OpConvert, 32'd0, 1'b0);            // midway
    queue_word(mmlr_pkg::OpConvert, -32'sd100, 1'b0);        // below minimum
    queue_word(mmlr_pkg::OpConvert, 32'd1000, 1'b0);         // above maximum
    queue_word(mmlr_pkg::OpMeasure, 32'h7FFF_FFFF, 1'b1);    // full signed range
    queue_word(mmlr_pkg::OpMeasure, 32'h8000_0000, 1'b0);
    queue_word(mmlr_pkg::OpConvert, 32'h7FFF_FFFF, 1'b0);
    queue_word(mmlr_pkg::OpConvert, 32'h8000_0000, 1'b1);
    queue_word(mmlr_pkg::OpConvert, 32'd0, 1'b0);
    queue_word(mmlr_pkg::OpConvert, 32'hFFFF_FFFF, 1'b0);
    queue_word(mmlr_pkg::OpMeasure, 32'd42, 1'b1);           // single-sample frame: zero range
    queue_word(mmlr_pkg::OpConvert, 32'd42, 1'b0);
    queue_word(mmlr_pkg::OpConvert, 32'd43, 1'b0);
    queue_word(mmlr_pkg::OpMeasure, 32'h8000_0000, 1'b1);
    queue_word(mmlr_pkg::OpMeasure, 32'h8000_0001, 1'b0);    // range of one
    queue_word(mmlr_pkg::OpConvert, 32'h8000_0001, 1'b0);
    queue_word(mmlr_pkg::OpConvert, 32'h8000_0000, 1'b0);
    drain();

    for (int s = 0; s < NumSettings; s++) begin
      // Write both registers in random order while the block is idle.
      if ($urandom_range(0, 1)) begin
        write_reg(mmlr_pkg::CfgOutMin, set_lo[s]);
        write_reg(mmlr_pkg::CfgOutMax, set_hi[s]);
      end else begin
        write_reg(mmlr_pkg::CfgOutMax, set_hi[s]);
        write_reg(mmlr_pkg::CfgOutMin, set_lo[s]);
      end
      @(negedge clk_i);
      phase_start = words_queued;
      while (words_queued - phase_start < PhaseWords) add_frame();
      // Hold the receiver once, under the widest span.
      if (s == 0) hold_req <= 1'b1;
      drain();
    end

    $display("sent %0d words over %0d range settings with %0d register writes",
             words_sent, NumSettings + 1, reg_writes);
    $display("checked %0d levels, %0d of them zero-range, %0d errors",
             levels_checked, zero_ranges, level_errors);
    if (level_errors == 0 && level_expect.size() == 0) begin
      $display("** minmax_level_rescaler: PASSED **");
    end else begin
      $display("** minmax_level_rescaler: FAILED **");
    end
    $finish;
  end

endmodule

// File: files.f
sv/mmlr_pkg.sv
sv/mmlr_scale_div.sv
sv/minmax_level_rescaler.sv
verif/minmax_level_rescaler_tb.sv
